// File: rtl/pbfm_pkg.sv
package pbfm_pkg;

  localparam int DEF_NUM_FRAMES = 16;
  localparam int DEF_TIME_BITS = 32;

  localparam int FRAME_W = 4;
  localparam int MAX_POOL = 16;
  localparam int PAGE_W = 31;
  localparam int FIX_W = 16;
  localparam int CNT_W = 32;
  localparam int NSIZE_W = 5;
  localparam int STEP_W = 6;

  localparam logic [FIX_W-1:0] FIX_MAX = '1;

  localparam logic [2:0] MODE_PIN = 3'd0;
  localparam logic [2:0] MODE_UNPIN = 3'd1;
  localparam logic [2:0] MODE_DIRTY = 3'd2;
  localparam logic [2:0] MODE_FORCE = 3'd3;
  localparam logic [2:0] MODE_FLUSH_UNPINNED = 3'd4;
  localparam logic [2:0] MODE_FLUSH_ALL = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_ALL_PINNED = 2'd2;
  localparam logic [1:0] ST_FIX_FULL = 2'd3;

  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_CLOCK = 2'd2;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_FRAMES = 1'b1;

  // search wave handed from cell to cell
  typedef struct packed {
    logic vld;
    logic hit;
    logic [FRAME_W-1:0] hidx;
    logic emp;
    logic [FRAME_W-1:0] eidx;
    logic bv;
    logic [FRAME_W-1:0] bidx;
  } carry_t;

  typedef struct packed {
    logic we;
    logic [FRAME_W-1:0] idx;
    logic set_valid;
    logic [PAGE_W-1:0] page;
    logic fix_we;
    logic [FIX_W-1:0] fix;
    logic dirty_we;
    logic dirty;
    logic load_we;
    logic acc_we;
    logic ref_we;
    logic ref_val;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic [PAGE_W-1:0] page;
    logic [FIX_W-1:0] fix;
    logic dirty;
    logic ref_bit;
  } view_t;

endpackage

// File: rtl/pbfm_cell.sv
module pbfm_cell import pbfm_pkg::*; #(
  parameter int IDX = 0,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic [NSIZE_W-1:0] n,
  input  logic [1:0] policy,
  input  logic [PAGE_W-1:0] req_page,
  input  carry_t cin,
  input  logic [TIME_BITS-1:0] cin_key,
  output carry_t cout,
  output logic [TIME_BITS-1:0] cout_key,
  input  cmd_t cmd,
  input  logic [TIME_BITS-1:0] cmd_load_t,
  input  logic [TIME_BITS-1:0] cmd_acc_t,
  output view_t view
);

  localparam logic [NSIZE_W-1:0] MY_N = NSIZE_W'(IDX);
  localparam logic [FRAME_W-1:0] MY_IDX = FRAME_W'(IDX);

  logic valid;
  logic [PAGE_W-1:0] page;
  logic [FIX_W-1:0] fix;
  logic dirty;
  logic [TIME_BITS-1:0] load_t;
  logic [TIME_BITS-1:0] acc_t;
  logic ref_bit;

  logic active, sel_me;
  logic [TIME_BITS-1:0] key;
  carry_t cout_next;
  logic [TIME_BITS-1:0] key_next;

  assign active = MY_N < n;
  assign sel_me = cmd.we && (cmd.idx == MY_IDX);
  assign key = (policy == POL_FIFO) ? load_t : acc_t;

  always_comb begin
    cout_next = cin;
    key_next = cin_key;
    if (active) begin
      if (!cin.hit && valid && page == req_page) begin
        cout_next.hit = 1'b1;
        cout_next.hidx = MY_IDX;
      end
      if (!cin.emp && !valid) begin
        cout_next.emp = 1'b1;
        cout_next.eidx = MY_IDX;
      end
      // strict less keeps the lowest index on ties
      if (valid && fix == '0 && (!cin.bv || key < cin_key)) begin
        cout_next.bv = 1'b1;
        cout_next.bidx = MY_IDX;
        key_next = key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout.vld <= 1'b0;
    end else begin
      cout.vld <= cin.vld;
    end
    cout.hit <= cout_next.hit;
    cout.hidx <= cout_next.hidx;
    cout.emp <= cout_next.emp;
    cout.eidx <= cout_next.eidx;
    cout.bv <= cout_next.bv;
    cout.bidx <= cout_next.bidx;
    cout_key <= key_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      fix <= '0;
      dirty <= 1'b0;
      load_t <= '0;
      acc_t <= '0;
      ref_bit <= 1'b0;
    end else if (sel_me) begin
      if (cmd.set_valid) valid <= 1'b1;
      if (cmd.fix_we) fix <= cmd.fix;
      if (cmd.dirty_we) dirty <= cmd.dirty;
      if (cmd.load_we) load_t <= cmd_load_t;
      if (cmd.acc_we) acc_t <= cmd_acc_t;
      if (cmd.ref_we) ref_bit <= cmd.ref_val;
    end
  end

  always_ff @(posedge clk) begin
    if (sel_me && cmd.set_valid) page <= cmd.page;
  end

  assign view = '{valid: valid, page: page, fix: fix, dirty: dirty, ref_bit: ref_bit};

endmodule

// File: rtl/page_buffer_frame_manager_top.sv
// a pin or page request runs its search wave through the registered frame cells, then a
//   decision state issues its result or passes to a hit, lookup, evict or load state
// a CLOCK miss adds up to 2n sweep steps; a flush scans the frames and gives its final result,
//   if any, once the scan ends, later only while the output stalls
// one request at a time: the next is taken once the current one has issued its results
// reset clears all frames to empty, times, counters and the clock hand; policy FIFO, 16 frames
module page_buffer_frame_manager_top import pbfm_pkg::*; #(
  parameter int NUM_FRAMES = DEF_NUM_FRAMES,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [NSIZE_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [2:0] mode,
  input  logic [PAGE_W-1:0] page_num,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] status,
  output logic [FRAME_W-1:0] frame,
  output logic write_back,
  output logic [PAGE_W-1:0] write_page,
  output logic read_load,
  output logic [FIX_W-1:0] fix_count_out,
  output logic dirty_out,
  output logic [CNT_W-1:0] reads_total,
  output logic [CNT_W-1:0] writes_total,
  output logic last
);

  localparam int USED = (NUM_FRAMES < MAX_POOL) ? NUM_FRAMES : MAX_POOL;
  localparam int IW = (USED > 1) ? $clog2(USED) : 1;
  localparam logic [NSIZE_W-1:0] USED_N = NSIZE_W'(USED);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WAVE = 4'd1;
  localparam logic [3:0] S_DEC = 4'd2;
  localparam logic [3:0] S_HIT = 4'd3;
  localparam logic [3:0] S_LK = 4'd4;
  localparam logic [3:0] S_EVICT = 4'd5;
  localparam logic [3:0] S_LOAD = 4'd6;
  localparam logic [3:0] S_CLK = 4'd7;
  localparam logic [3:0] S_FLUSH = 4'd8;
  localparam logic [3:0] S_FEND = 4'd9;

  logic [1:0] policy;
  logic [NSIZE_W-1:0] fiu, n;

  logic [3:0] state, state_next;
  logic [2:0] req_mode, req_mode_next;
  logic [PAGE_W-1:0] req_page, req_page_next;
  logic [PAGE_W-1:0] wave_page;
  carry_t res;
  logic [FRAME_W-1:0] sel, sel_next;
  logic wb, wb_next;
  logic [PAGE_W-1:0] wp, wp_next;
  logic [FRAME_W-1:0] hand, hand_next;
  logic [STEP_W-1:0] steps, steps_next;
  logic [NSIZE_W-1:0] fidx, fidx_next;
  logic pend, pend_next;
  logic [FRAME_W-1:0] pend_frame, pend_frame_next;
  logic [PAGE_W-1:0] pend_page, pend_page_next;
  logic [FIX_W-1:0] pend_fix, pend_fix_next;
  logic [CNT_W-1:0] pend_w, pend_w_next;
  logic [TIME_BITS-1:0] ltime, ltime_next;
  logic [CNT_W-1:0] rcnt, rcnt_next, wcnt, wcnt_next;

  carry_t chain [USED+1];
  logic [TIME_BITS-1:0] chain_key [USED+1];
  view_t views [USED];
  view_t rv;
  logic [FRAME_W-1:0] rd_idx;
  cmd_t cmd;
  logic [TIME_BITS-1:0] cmd_load_t, cmd_acc_t;
  logic start;

  logic can_emit, emit;
  logic [1:0] e_status;
  logic [FRAME_W-1:0] e_frame;
  logic e_wb;
  logic [PAGE_W-1:0] e_wp;
  logic e_rl;
  logic [FIX_W-1:0] e_fix;
  logic e_dirty;
  logic [CNT_W-1:0] e_reads, e_writes;
  logic e_last;

  logic [NSIZE_W-1:0] hand_inc;
  logic elig;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_FIFO;
      fiu <= NSIZE_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POLICY: policy <= cfg_data[1:0];
        REG_FRAMES: fiu <= cfg_data;
        default: ;
      endcase
    end
  end

  assign n = (fiu == '0) ? NSIZE_W'(1) : ((fiu > USED_N) ? USED_N : fiu);

  // the first cell compares at the accepting edge, before req_page is loaded
  assign wave_page = (state == S_IDLE) ? page_num : req_page;

  assign chain[0] = '{vld: start, hit: 1'b0, hidx: '0, emp: 1'b0, eidx: '0,
                      bv: 1'b0, bidx: '0};
  assign chain_key[0] = '0;

  for (genvar i = 0; i < USED; i++) begin : g_cell
    pbfm_cell #(.IDX(i), .TIME_BITS(TIME_BITS)) u_cell (
      .clk(clk),
      .rst(rst),
      .n(n),
      .policy(policy),
      .req_page(wave_page),
      .cin(chain[i]),
      .cin_key(chain_key[i]),
      .cout(chain[i+1]),
      .cout_key(chain_key[i+1]),
      .cmd(cmd),
      .cmd_load_t(cmd_load_t),
      .cmd_acc_t(cmd_acc_t),
      .view(views[i])
    );
  end

  assign rd_idx = (state == S_CLK) ? hand :
                  (state == S_FLUSH) ? fidx[FRAME_W-1:0] : sel;
  assign rv = views[rd_idx[IW-1:0]];
  assign can_emit = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign hand_inc = NSIZE_W'(hand) + NSIZE_W'(1);
  assign elig = rv.valid && rv.dirty && (req_mode == MODE_FLUSH_ALL || rv.fix == '0);

  always_comb begin
    state_next = state;
    req_mode_next = req_mode;
    req_page_next = req_page;
    sel_next = sel;
    wb_next = wb;
    wp_next = wp;
    hand_next = hand;
    steps_next = steps;
    fidx_next = fidx;
    pend_next = pend;
    pend_frame_next = pend_frame;
    pend_page_next = pend_page;
    pend_fix_next = pend_fix;
    pend_w_next = pend_w;
    ltime_next = ltime;
    rcnt_next = rcnt;
    wcnt_next = wcnt;
    start = 1'b0;
    cmd = '0;
    cmd_load_t = ltime + TIME_BITS'(1);
    cmd_acc_t = ltime + TIME_BITS'(1);
    emit = 1'b0;
    e_status = ST_OK;
    e_frame = sel;
    e_wb = 1'b0;
    e_wp = '0;
    e_rl = 1'b0;
    e_fix = '0;
    e_dirty = 1'b0;
    e_reads = rcnt;
    e_writes = wcnt;
    e_last = 1'b1;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_mode_next = mode;
          req_page_next = page_num;
          if (mode == MODE_PIN || mode == MODE_UNPIN || mode == MODE_DIRTY ||
              mode == MODE_FORCE) begin
            start = 1'b1;
            state_next = S_WAVE;
          end else if (mode == MODE_FLUSH_UNPINNED || mode == MODE_FLUSH_ALL) begin
            fidx_next = '0;
            pend_next = 1'b0;
            state_next = S_FLUSH;
          end
        end
      end
      S_WAVE: begin
        if (chain[USED].vld) state_next = S_DEC;
      end
      S_DEC: begin
        if (req_mode == MODE_PIN) begin
          if (res.hit) begin
            sel_next = res.hidx;
            state_next = S_HIT;
          end else if (res.emp) begin
            sel_next = res.eidx;
            wb_next = 1'b0;
            wp_next = '0;
            state_next = S_LOAD;
          end else if (policy == POL_CLOCK) begin
            if (NSIZE_W'(hand) >= n) hand_next = '0;
            steps_next = '0;
            state_next = S_CLK;
          end else if (res.bv) begin
            sel_next = res.bidx;
            state_next = S_EVICT;
          end else if (can_emit) begin
            emit = 1'b1;
            e_status = ST_ALL_PINNED;
            e_frame = '0;
            state_next = S_IDLE;
          end
        end else if (res.hit) begin
          sel_next = res.hidx;
          state_next = S_LK;
        end else if (can_emit) begin
          emit = 1'b1;
          e_status = ST_NOT_FOUND;
          e_frame = '0;
          state_next = S_IDLE;
        end
      end
      S_HIT: begin
        if (can_emit) begin
          emit = 1'b1;
          e_dirty = rv.dirty;
          if (rv.fix == FIX_MAX) begin
            e_status = ST_FIX_FULL;
            e_fix = rv.fix;
          end else begin
            e_fix = rv.fix + FIX_W'(1);
            cmd.we = 1'b1;
            cmd.idx = sel;
            cmd.fix_we = 1'b1;
            cmd.fix = e_fix;
            cmd.acc_we = 1'b1;
            cmd.ref_we = 1'b1;
            cmd.ref_val = 1'b1;
            ltime_next = ltime + TIME_BITS'(1);
          end
          state_next = S_IDLE;
        end
      end
      S_LK: begin
        if (can_emit) begin
          emit = 1'b1;
          cmd.idx = sel;
          e_fix = rv.fix;
          e_dirty = rv.dirty;
          case (req_mode)
            MODE_UNPIN: begin
              if (rv.fix == '0) begin
                e_status = ST_NOT_FOUND;
              end else begin
                e_fix = rv.fix - FIX_W'(1);
                cmd.we = 1'b1;
                cmd.fix_we = 1'b1;
                cmd.fix = e_fix;
              end
            end
            MODE_DIRTY: begin
              e_dirty = 1'b1;
              cmd.we = 1'b1;
              cmd.dirty_we = 1'b1;
              cmd.dirty = 1'b1;
            end
            default: begin
              // force page: write always requested, counted only when dirty
              e_wb = 1'b1;
              e_wp = rv.page;
              e_dirty = 1'b0;
              if (rv.dirty) begin
                wcnt_next = wcnt + CNT_W'(1);
                e_writes = wcnt_next;
                cmd.we = 1'b1;
                cmd.dirty_we = 1'b1;
                cmd.dirty = 1'b0;
              end
            end
          endcase
          state_next = S_IDLE;
        end
      end
      S_EVICT: begin
        wb_next = rv.dirty;
        wp_next = rv.dirty ? rv.page : '0;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (can_emit) begin
          if (wb) wcnt_next = wcnt + CNT_W'(1);
          rcnt_next = rcnt + CNT_W'(1);
          cmd.we = 1'b1;
          cmd.idx = sel;
          cmd.set_valid = 1'b1;
          cmd.page = req_page;
          cmd.fix_we = 1'b1;
          cmd.fix = FIX_W'(1);
          cmd.dirty_we = 1'b1;
          cmd.dirty = 1'b0;
          cmd.load_we = 1'b1;
          cmd.acc_we = 1'b1;
          cmd.ref_we = 1'b1;
          cmd.ref_val = 1'b1;
          cmd_acc_t = ltime + TIME_BITS'(2);
          ltime_next = ltime + TIME_BITS'(2);
          emit = 1'b1;
          e_wb = wb;
          e_wp = wp;
          e_rl = 1'b1;
          e_fix = FIX_W'(1);
          e_reads = rcnt_next;
          e_writes = wcnt_next;
          state_next = S_IDLE;
        end
      end
      S_CLK: begin
        if (steps == STEP_W'({n, 1'b0})) begin
          if (can_emit) begin
            emit = 1'b1;
            e_status = ST_ALL_PINNED;
            e_frame = '0;
            state_next = S_IDLE;
          end
        end else begin
          hand_next = (hand_inc >= n) ? '0 : hand_inc[FRAME_W-1:0];
          steps_next = steps + STEP_W'(1);
          if (rv.valid && rv.fix == '0) begin
            if (!rv.ref_bit) begin
              sel_next = hand;
              state_next = S_EVICT;
            end else begin
              // second chance
              cmd.we = 1'b1;
              cmd.idx = hand;
              cmd.ref_we = 1'b1;
              cmd.ref_val = 1'b0;
            end
          end
        end
      end
      S_FLUSH: begin
        e_last = 1'b0;
        e_status = ST_OK;
        e_frame = pend_frame;
        e_wb = 1'b1;
        e_wp = pend_page;
        e_fix = pend_fix;
        e_writes = pend_w;
        if (fidx == n) begin
          state_next = S_FEND;
        end else if (!elig) begin
          fidx_next = fidx + NSIZE_W'(1);
        end else if (!pend || can_emit) begin
          // hold each result back one step so the final one can carry last
          emit = pend;
          wcnt_next = wcnt + CNT_W'(1);
          cmd.we = 1'b1;
          cmd.idx = fidx[FRAME_W-1:0];
          cmd.dirty_we = 1'b1;
          cmd.dirty = 1'b0;
          pend_next = 1'b1;
          pend_frame_next = fidx[FRAME_W-1:0];
          pend_page_next = rv.page;
          pend_fix_next = rv.fix;
          pend_w_next = wcnt_next;
          fidx_next = fidx + NSIZE_W'(1);
        end
      end
      S_FEND: begin
        e_frame = pend_frame;
        e_wb = 1'b1;
        e_wp = pend_page;
        e_fix = pend_fix;
        e_writes = pend_w;
        if (!pend) begin
          state_next = S_IDLE;
        end else if (can_emit) begin
          emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hand <= '0;
      ltime <= '0;
      rcnt <= '0;
      wcnt <= '0;
      pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      hand <= hand_next;
      ltime <= ltime_next;
      rcnt <= rcnt_next;
      wcnt <= wcnt_next;
      pend <= pend_next;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    req_mode <= req_mode_next;
    req_page <= req_page_next;
    sel <= sel_next;
    wb <= wb_next;
    wp <= wp_next;
    steps <= steps_next;
    fidx <= fidx_next;
    pend_frame <= pend_frame_next;
    pend_page <= pend_page_next;
    pend_fix <= pend_fix_next;
    pend_w <= pend_w_next;
    if (state == S_WAVE && chain[USED].vld) res <= chain[USED];
    if (emit) begin
      status <= e_status;
      frame <= e_frame;
      write_back <= e_wb;
      write_page <= e_wp;
      read_load <= e_rl;
      fix_count_out <= e_fix;
      dirty_out <= e_dirty;
      reads_total <= e_reads;
      writes_total <= e_writes;
      last <= e_last;
    end
  end

endmodule
